@@ design/binary_reply_frame_parser_defines.svh @@
`ifndef BINARY_REPLY_FRAME_PARSER_DEFINES_SVH
`define BINARY_REPLY_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define BRFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brfp assertion failed");

// next-cycle implication, sampled on clk, idle during reset
`define BRFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brfp assertion failed");

`endif

@@ design/brfp_pkg.sv @@
`default_nettype none

package brfp_pkg;

  localparam int unsigned HEADER_BYTES      = 4;
  localparam int unsigned NUMERIC_MAX_BYTES = 4;
  localparam int unsigned LEN_BYTE_POS      = 3;
  localparam int unsigned ERR_BYTE_POS      = 4;
  localparam int unsigned CNT_W             = 10;
  localparam logic [7:0]  CHECK_TARGET      = 8'h5A;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_OK     = 3'd1,
    ST_VALUE  = 3'd2,
    ST_DRVERR = 3'd3,
    ST_BADSUM = 3'd4,
    ST_EXTRA  = 3'd5
  } brfp_status_t;

  typedef struct packed {
    brfp_status_t status;
    logic [31:0]  numeric_value;
    logic         value_is_numeric;
    logic [7:0]   drive_error_code;
    logic [7:0]   payload_byte;
    logic         payload_byte_valid;
  } brfp_result_t;

endpackage

`default_nettype wire

@@ design/brfp_core.sv @@
`default_nettype none
`include "binary_reply_frame_parser_defines.svh"

module brfp_core #(
  parameter int unsigned NUMERIC_MAX_BYTES = brfp_pkg::NUMERIC_MAX_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  start_new,
  output brfp_pkg::brfp_result_t     res
);
  import brfp_pkg::*;

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       xor_sum_r, xor_sum_nxt;
  logic [7:0]       payload_words_r, payload_words_nxt;
  logic [7:0]       header_error_r, header_error_nxt;
  logic             header_done_r, header_done_nxt;
  logic             reply_done_r, reply_done_nxt;
  logic [31:0]      value_accum_r, value_accum_nxt;

  logic [CNT_W-1:0] eff_count;
  logic [7:0]       eff_xor;
  logic [7:0]       eff_words;
  logic [7:0]       eff_err;
  logic             eff_hdr;
  logic             eff_done;
  logic [31:0]      eff_accum;
  logic [CNT_W-1:0] data_len;

  always_comb begin
    eff_count = start_new ? '0 : byte_count_r;
    eff_xor   = start_new ? '0 : xor_sum_r;
    eff_words = start_new ? '0 : payload_words_r;
    eff_err   = start_new ? '0 : header_error_r;
    eff_hdr   = start_new ? 1'b0 : header_done_r;
    eff_done  = start_new ? 1'b0 : reply_done_r;
    eff_accum = start_new ? '0 : value_accum_r;

    byte_count_nxt    = eff_count;
    xor_sum_nxt       = eff_xor;
    payload_words_nxt = eff_words;
    header_error_nxt  = eff_err;
    header_done_nxt   = eff_hdr;
    reply_done_nxt    = eff_done;
    value_accum_nxt   = eff_accum;
    data_len          = '0;

    res = '0;
    res.status = ST_BUSY;

    if (eff_done) begin
      res.status = ST_EXTRA;
    end else begin
      xor_sum_nxt    = eff_xor ^ rx_byte;
      byte_count_nxt = eff_count + CNT_W'(1);
      if (eff_hdr) begin
        res.payload_byte       = rx_byte;
        res.payload_byte_valid = 1'b1;
        value_accum_nxt        = {eff_accum[23:0], rx_byte};
        data_len               = byte_count_nxt - CNT_W'(HEADER_BYTES);
        reply_done_nxt         = (data_len[CNT_W-1:1] == {1'b0, eff_words});
      end else begin
        if (byte_count_nxt == CNT_W'(LEN_BYTE_POS)) begin
          payload_words_nxt = rx_byte;
        end else if (byte_count_nxt == CNT_W'(ERR_BYTE_POS)) begin
          header_error_nxt = rx_byte;
        end
        if (byte_count_nxt == CNT_W'(HEADER_BYTES)) begin
          header_done_nxt = 1'b1;
          reply_done_nxt  = (payload_words_nxt == 8'd0);
        end
      end
      if (reply_done_nxt) begin
        if (xor_sum_nxt != CHECK_TARGET) begin
          res.status = ST_BADSUM;
        end else if (header_error_nxt != 8'd0) begin
          res.status           = ST_DRVERR;
          res.drive_error_code = header_error_nxt;
        end else if (payload_words_nxt == 8'd0) begin
          res.status = ST_OK;
        end else begin
          res.status = ST_VALUE;
          if ({payload_words_nxt, 1'b0} <= 9'(NUMERIC_MAX_BYTES)) begin
            res.value_is_numeric = 1'b1;
            res.numeric_value    = value_accum_nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      xor_sum_r       <= '0;
      payload_words_r <= '0;
      header_error_r  <= '0;
      header_done_r   <= 1'b0;
      reply_done_r    <= 1'b0;
      value_accum_r   <= '0;
    end else if (step_en) begin
      byte_count_r    <= byte_count_nxt;
      xor_sum_r       <= xor_sum_nxt;
      payload_words_r <= payload_words_nxt;
      header_error_r  <= header_error_nxt;
      header_done_r   <= header_done_nxt;
      reply_done_r    <= reply_done_nxt;
      value_accum_r   <= value_accum_nxt;
    end
  end

  `BRFP_ASSERT_NOW(a_echo_only_in_payload, res.payload_byte_valid, (res.status != ST_OK) && (res.status != ST_EXTRA) && header_done_r)
  `BRFP_ASSERT_NOW(a_numeric_only_value, res.value_is_numeric, res.status == ST_VALUE)
  `BRFP_ASSERT_NEXT(a_extra_holds_state, step_en && (res.status == ST_EXTRA), $stable(byte_count_r) && $stable(xor_sum_r) && reply_done_r)
  `BRFP_ASSERT_NEXT(a_done_sticky, !step_en && reply_done_r, reply_done_r)

endmodule

`default_nettype wire

@@ design/binary_reply_frame_parser.sv @@
// Binary reply frame parser.
// Input channel (in_*): one reply byte per transaction in in_tdata; in_tuser set
// clears the parser before that byte is taken, so it marks the first byte of a reply.
// Output channel (out_*): exactly one result per input byte, in order. Status is
// in progress until the reply completes, then ok, value, drive error or bad
// checksum; bytes after completion report too much data until the next start.
// Payload bytes are echoed with out_tuser[4] set; short payloads also come out
// as a big-endian number on the completing byte.
// Path: an accepted byte is held in the input register; its result is then registered
// in the result register that drives out_*. Throughput: one byte per cycle unless
// stalled, set by the parser state update between the input and result registers.
// Stall: while out_tvalid is high and out_tready is low the result register holds; a byte is still
// taken only while the input register is empty, and in_tready stays low while
// it is full until the result register drains.
// Reset: rst_n low clears both valid flags and all parser state, as if a new
// reply were starting.
`default_nettype none

module binary_reply_frame_parser #(
  parameter int unsigned NUMERIC_MAX_BYTES = brfp_pkg::NUMERIC_MAX_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] start_new
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] numeric_value, [39:32] drive_error_code,
                                       // [47:40] payload_byte
  output logic [4:0]       out_tuser   // [2:0] reply_status, [3] value_is_numeric,
                                       // [4] payload_byte_valid
);
  import brfp_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_start_r;
  logic         out_valid_r;
  brfp_result_t out_res_r;
  brfp_result_t core_res;
  logic         advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  brfp_core #(
    .NUMERIC_MAX_BYTES (NUMERIC_MAX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .rx_byte   (in_byte_r),
    .start_new (in_start_r),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.payload_byte, out_res_r.drive_error_code,
                       out_res_r.numeric_value};
  assign out_tuser  = {out_res_r.payload_byte_valid, out_res_r.value_is_numeric,
                       out_res_r.status};

endmodule

`default_nettype wire
